/* rtl/i2c_master_byte_sequencer_defines.svh */
// assertion helpers for the byte sequencer
`ifndef I2C_MASTER_BYTE_SEQUENCER_DEFINES_SVH
`define I2C_MASTER_BYTE_SEQUENCER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define I2CMS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define I2CMS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/i2cms_pkg.sv */
package i2cms_pkg;

    localparam int TICK_W  = 16;
    localparam int BYTE_W  = 8;
    localparam int OP_W    = 3;
    localparam int UNITS_W = 3;
    localparam int BITS_W  = 4;
    localparam int CFG_IDX_W = 1;

    localparam logic [OP_W-1:0] OP_NONE  = 3'd0;
    localparam logic [OP_W-1:0] OP_START = 3'd1;
    localparam logic [OP_W-1:0] OP_STOP  = 3'd2;
    localparam logic [OP_W-1:0] OP_WRITE = 3'd3;
    localparam logic [OP_W-1:0] OP_READ  = 3'd4;
    localparam logic [OP_W-1:0] OP_WACK  = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_UNIT_TICKS  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = 1'b1;

    localparam logic [TICK_W-1:0] UNIT_TICKS_RST  = 16'd500;
    localparam logic [TICK_W-1:0] ACK_TIMEOUT_RST = 16'd2500;

    localparam logic [UNITS_W-1:0] UNITS_LONG  = 3'd4;
    localparam logic [UNITS_W-1:0] UNITS_HALF  = 3'd2;
    localparam logic [UNITS_W-1:0] UNITS_SHORT = 3'd1;

    localparam logic [BITS_W-1:0] BITS_PER_BYTE = 4'd8;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [BYTE_W-1:0] tx_byte;
        logic              send_ack;
        logic              sda_in;
    } t_in_word;

    typedef struct packed {
        logic              scl;
        logic              sda_out;
        logic              sda_enable;
        logic              busy_res;
        logic              done_res;
        logic [BYTE_W-1:0] rx_byte;
        logic              ack_failed;
    } t_out_word;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [TICK_W-1:0]    value;
    } t_cfg_word;

endpackage

/* rtl/i2cms_in_if.sv */
interface i2cms_in_if;
    logic                 valid;
    logic                 ready;
    i2cms_pkg::t_in_word  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/i2cms_out_if.sv */
interface i2cms_out_if;
    logic                 valid;
    logic                 ready;
    i2cms_pkg::t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/i2cms_cfg_if.sv */
interface i2cms_cfg_if;
    logic                 valid;
    logic                 ready;
    i2cms_pkg::t_cfg_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/i2c_master_byte_sequencer.sv */
// Byte-level I2C master sequencer.
// i_in carries one word per bus tick: op, tx_byte, send_ack and the sampled
// sda_in level. Every accepted word yields exactly one word on o_out with the
// scl/sda levels, sda_enable, busy_res, done_res, rx_byte and ack_failed.
// Commands (start, stop, write, read, wait ack) are taken only while idle;
// ops given while busy are ignored. Line changes are spaced by 1, 2 or 4
// units of unit_ticks ticks.
// i_cfg writes unit_ticks (index 0) and ack_timeout (index 1); it is always
// ready and should be used only while the block is idle.
// The result word for an input word is registered and valid in the cycle
// after it is accepted. Throughput: one word per cycle if o_out is ready; the
// single output register accepts a new word in the cycle the result is taken.
// If o_out stalls, i_in ready drops while the output register is full, so no
// ticks are lost or repeated. Reset (synchronous, active low) returns the bus
// state to idle with scl and sda driven high, and restores the register
// defaults 500 and 2500.
`include "i2c_master_byte_sequencer_defines.svh"

module i2c_master_byte_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    i2cms_in_if.sink    i_in,
    i2cms_out_if.source o_out,
    i2cms_cfg_if.sink   i_cfg
);

    typedef enum logic [3:0] {
        PH_IDLE, PH_ST1, PH_ST2, PH_SP1, PH_SP2, PH_WR_HI, PH_WR_LO, PH_WR_NEXT,
        PH_RD_HI, PH_RD_NEXT, PH_RA_HI, PH_RA_END, PH_AK_HI, PH_AK_POLL
    } t_phase;

    logic [i2cms_pkg::TICK_W-1:0]  r_unit_ticks;
    logic [i2cms_pkg::TICK_W-1:0]  r_ack_timeout;

    t_phase                         r_phase, n_phase;
    logic [i2cms_pkg::TICK_W-1:0]  r_delay_count, n_delay_count;
    logic [i2cms_pkg::UNITS_W-1:0] r_units_left, n_units_left;
    logic [i2cms_pkg::BITS_W-1:0]  r_bit_count, n_bit_count;
    logic [i2cms_pkg::BYTE_W-1:0]  r_shift, n_shift;
    logic [i2cms_pkg::TICK_W-1:0]  r_poll_count, n_poll_count;
    logic [i2cms_pkg::BYTE_W-1:0]  r_rx_hold, n_rx_hold;
    logic                           r_ack_choice, n_ack_choice;
    logic                           r_scl, n_scl;
    logic                           r_sda, n_sda;
    logic                           r_sda_oe, n_sda_oe;
    logic                           r_fail, n_fail;
    logic                           n_done;

    logic                           r_out_valid;
    i2cms_pkg::t_out_word           r_out, n_out;

    logic                           w_accept;
    logic [i2cms_pkg::TICK_W-1:0]  w_unit;
    i2cms_pkg::t_in_word            w_in;

    assign w_in       = i_in.data;
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_unit     = (r_unit_ticks == '0) ? i2cms_pkg::TICK_W'(1) : r_unit_ticks;

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit_ticks  <= i2cms_pkg::UNIT_TICKS_RST;
            r_ack_timeout <= i2cms_pkg::ACK_TIMEOUT_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.data.index)
                i2cms_pkg::CFG_UNIT_TICKS:  r_unit_ticks  <= i_cfg.data.value;
                i2cms_pkg::CFG_ACK_TIMEOUT: r_ack_timeout <= i_cfg.data.value;
                default: ;
            endcase
        end
    end

    always_comb begin
        logic do_act;
        n_phase       = r_phase;
        n_delay_count = r_delay_count;
        n_units_left  = r_units_left;
        n_bit_count   = r_bit_count;
        n_shift       = r_shift;
        n_poll_count  = r_poll_count;
        n_rx_hold     = r_rx_hold;
        n_ack_choice  = r_ack_choice;
        n_scl         = r_scl;
        n_sda         = r_sda;
        n_sda_oe      = r_sda_oe;
        n_fail        = r_fail;
        n_done        = 1'b0;
        do_act        = 1'b0;

        if (r_phase == PH_IDLE) begin
            unique case (w_in.op)
                i2cms_pkg::OP_START: begin
                    n_sda_oe = 1'b1; n_sda = 1'b1; n_scl = 1'b1;
                    n_units_left = i2cms_pkg::UNITS_LONG;
                    n_delay_count = w_unit; n_phase = PH_ST1;
                end
                i2cms_pkg::OP_STOP: begin
                    n_sda_oe = 1'b1; n_scl = 1'b0; n_sda = 1'b0;
                    n_units_left = i2cms_pkg::UNITS_LONG;
                    n_delay_count = w_unit; n_phase = PH_SP1;
                end
                i2cms_pkg::OP_WRITE: begin
                    n_sda_oe = 1'b1; n_scl = 1'b0;
                    n_sda = w_in.tx_byte[i2cms_pkg::BYTE_W-1];
                    n_shift = {w_in.tx_byte[i2cms_pkg::BYTE_W-2:0], 1'b0};
                    n_bit_count = '0;
                    n_units_left = i2cms_pkg::UNITS_HALF;
                    n_delay_count = w_unit; n_phase = PH_WR_HI;
                end
                i2cms_pkg::OP_READ: begin
                    n_sda_oe = 1'b0; n_sda = 1'b1; n_scl = 1'b0;
                    n_bit_count = '0; n_shift = '0; n_ack_choice = w_in.send_ack;
                    n_units_left = i2cms_pkg::UNITS_HALF;
                    n_delay_count = w_unit; n_phase = PH_RD_HI;
                end
                i2cms_pkg::OP_WACK: begin
                    n_sda_oe = 1'b0; n_sda = 1'b1; n_poll_count = '0;
                    n_units_left = i2cms_pkg::UNITS_SHORT;
                    n_delay_count = w_unit; n_phase = PH_AK_HI;
                end
                default: ;
            endcase
        end else if (r_phase == PH_AK_POLL) begin
            do_act = 1'b1;
        end else if (r_delay_count > i2cms_pkg::TICK_W'(1)) begin
            n_delay_count = r_delay_count - i2cms_pkg::TICK_W'(1);
        end else begin
            n_delay_count = '0;
            if (r_units_left > i2cms_pkg::UNITS_W'(1)) begin
                n_units_left  = r_units_left - i2cms_pkg::UNITS_W'(1);
                n_delay_count = w_unit;
            end else begin
                n_units_left = '0;
                do_act       = 1'b1;
            end
        end

        if (do_act) begin
            unique case (r_phase)
                PH_ST1: begin
                    n_sda = 1'b0;
                    n_units_left = i2cms_pkg::UNITS_LONG;
                    n_delay_count = w_unit; n_phase = PH_ST2;
                end
                PH_ST2: begin
                    n_scl = 1'b0;
                    n_phase = PH_IDLE; n_units_left = '0; n_delay_count = '0; n_done = 1'b1;
                end
                PH_SP1: begin
                    n_scl = 1'b1; n_sda = 1'b1;
                    n_units_left = i2cms_pkg::UNITS_LONG;
                    n_delay_count = w_unit; n_phase = PH_SP2;
                end
                PH_WR_HI: begin
                    n_scl = 1'b1;
                    n_units_left = i2cms_pkg::UNITS_HALF;
                    n_delay_count = w_unit; n_phase = PH_WR_LO;
                end
                PH_WR_LO: begin
                    n_scl = 1'b0;
                    n_units_left = i2cms_pkg::UNITS_HALF;
                    n_delay_count = w_unit; n_phase = PH_WR_NEXT;
                end
                PH_WR_NEXT: begin
                    n_bit_count = r_bit_count + i2cms_pkg::BITS_W'(1);
                    if (n_bit_count >= i2cms_pkg::BITS_PER_BYTE) begin
                        n_phase = PH_IDLE; n_units_left = '0; n_delay_count = '0;
                        n_done = 1'b1;
                    end else begin
                        n_sda = r_shift[i2cms_pkg::BYTE_W-1];
                        n_shift = {r_shift[i2cms_pkg::BYTE_W-2:0], 1'b0};
                        n_units_left = i2cms_pkg::UNITS_HALF;
                        n_delay_count = w_unit; n_phase = PH_WR_HI;
                    end
                end
                PH_RD_HI: begin
                    n_scl = 1'b1;
                    n_shift = {r_shift[i2cms_pkg::BYTE_W-2:0], w_in.sda_in};
                    n_bit_count = r_bit_count + i2cms_pkg::BITS_W'(1);
                    n_units_left = i2cms_pkg::UNITS_SHORT;
                    n_delay_count = w_unit; n_phase = PH_RD_NEXT;
                end
                PH_RD_NEXT: begin
                    n_scl = 1'b0;
                    n_units_left = i2cms_pkg::UNITS_HALF;
                    n_delay_count = w_unit;
                    if (r_bit_count >= i2cms_pkg::BITS_PER_BYTE) begin
                        n_sda_oe = 1'b1;
                        n_sda = !r_ack_choice;
                        n_phase = PH_RA_HI;
                    end else begin
                        n_phase = PH_RD_HI;
                    end
                end
                PH_RA_HI: begin
                    n_scl = 1'b1;
                    n_units_left = i2cms_pkg::UNITS_HALF;
                    n_delay_count = w_unit; n_phase = PH_RA_END;
                end
                PH_RA_END: begin
                    n_scl = 1'b0; n_rx_hold = r_shift;
                    n_phase = PH_IDLE; n_units_left = '0; n_delay_count = '0; n_done = 1'b1;
                end
                PH_AK_HI: begin
                    n_scl = 1'b1;
                    n_units_left = i2cms_pkg::UNITS_SHORT;
                    n_delay_count = w_unit; n_phase = PH_AK_POLL;
                end
                PH_AK_POLL: begin
                    n_units_left = '0;
                    if (!w_in.sda_in) begin
                        n_scl = 1'b0; n_fail = 1'b0;
                        n_phase = PH_IDLE; n_delay_count = '0; n_done = 1'b1;
                    end else if (r_poll_count >= r_ack_timeout) begin
                        n_fail = 1'b1;
                        n_sda_oe = 1'b1; n_scl = 1'b0; n_sda = 1'b0;
                        n_units_left = i2cms_pkg::UNITS_LONG;
                        n_delay_count = w_unit; n_phase = PH_SP1;
                    end else begin
                        n_poll_count = r_poll_count + i2cms_pkg::TICK_W'(1);
                    end
                end
                default: begin
                    n_phase = PH_IDLE; n_units_left = '0; n_delay_count = '0; n_done = 1'b1;
                end
            endcase
        end

        n_out.scl        = n_scl;
        n_out.sda_out    = n_sda_oe ? n_sda : 1'b1;
        n_out.sda_enable = n_sda_oe;
        n_out.busy_res   = (n_phase != PH_IDLE);
        n_out.done_res   = n_done;
        n_out.rx_byte    = n_rx_hold;
        n_out.ack_failed = n_fail;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_delay_count <= '0;
            r_units_left  <= '0;
            r_bit_count   <= '0;
            r_shift       <= '0;
            r_poll_count  <= '0;
            r_rx_hold     <= '0;
            r_ack_choice  <= 1'b0;
            r_scl         <= 1'b1;
            r_sda         <= 1'b1;
            r_sda_oe      <= 1'b1;
            r_fail        <= 1'b0;
            r_out_valid   <= 1'b0;
            r_out         <= '0;
        end else begin
            r_out_valid <= w_accept || (r_out_valid && !o_out.ready);
            if (w_accept) begin
                r_phase       <= n_phase;
                r_delay_count <= n_delay_count;
                r_units_left  <= n_units_left;
                r_bit_count   <= n_bit_count;
                r_shift       <= n_shift;
                r_poll_count  <= n_poll_count;
                r_rx_hold     <= n_rx_hold;
                r_ack_choice  <= n_ack_choice;
                r_scl         <= n_scl;
                r_sda         <= n_sda;
                r_sda_oe      <= n_sda_oe;
                r_fail        <= n_fail;
                r_out         <= n_out;
            end
        end
    end

    `I2CMS_ASSERT_NOW(a_idle_timers_clear, r_phase == PH_IDLE, r_units_left == '0 && r_delay_count == '0, "idle with timers running")
    `I2CMS_ASSERT_NEXT(a_done_goes_idle, w_accept && n_done, r_phase == PH_IDLE && o_out.valid && o_out.data.done_res, "done without idle")
    `I2CMS_ASSERT_NEXT(a_delay_counts_down, w_accept && r_phase != PH_IDLE && r_phase != PH_AK_POLL && r_delay_count > i2cms_pkg::TICK_W'(1), r_delay_count == $past(r_delay_count) - i2cms_pkg::TICK_W'(1), "delay count skipped")

endmodule
